// ===== rtl/chc_pkg.sv =====
package chc_pkg;

  // Geometry of the calorimeter and event limits.
  localparam int unsigned LAYERS     = 10;
  localparam int unsigned MAX_CELLS  = 4096;
  localparam int unsigned FRONT_END  = 3;
  localparam int unsigned MIDDLE_END = 6;

  // Field widths.
  localparam int unsigned ENERGY_W   = 24;
  localparam int unsigned LAYER_W    = 4;
  localparam int unsigned PRIMARY_W  = 32;
  localparam int unsigned CELLS_W    = 13;
  localparam int unsigned NLAYERS_W  = 4;
  localparam int unsigned CELL_SQ_W  = 2 * CELLS_W;
  localparam int unsigned LAYER_SQ_W = 2 * NLAYERS_W;

  // Running total widths.
  localparam int unsigned VALID_TOT_W   = 32;
  localparam int unsigned DET_TOT_W     = 32;
  localparam int unsigned CELL_SUM_W    = 48;
  localparam int unsigned CELL_SQSUM_W  = 64;
  localparam int unsigned LAYER_SUM_W   = 40;
  localparam int unsigned LAYER_SQSUM_W = 48;

  // Stream data widths.
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 288;
  localparam int unsigned OUT_USED_W = CELLS_W + NLAYERS_W + 1 + VALID_TOT_W + DET_TOT_W
                                     + CELL_SUM_W + CELL_SQSUM_W + LAYER_SUM_W
                                     + LAYER_SQSUM_W;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;

  // Threshold register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT  = 2'd0,
    REG_MIDDLE = 2'd1,
    REG_BACK   = 2'd2
  } cfg_reg_e;

  // Segment thresholds, one per segment.
  typedef struct packed {
    logic signed [ENERGY_W-1:0] front;
    logic signed [ENERGY_W-1:0] middle;
    logic signed [ENERGY_W-1:0] back;
  } thr_t;

  // One input cell item.
  typedef struct packed {
    logic signed [ENERGY_W-1:0]  energy;
    logic        [LAYER_W-1:0]   layer;
    logic                        has_cell;
    logic signed [PRIMARY_W-1:0] primary;
    logic                        last;
  } cell_item_t;

  // Closed event summary handed from the event tally to the statistics stages.
  typedef struct packed {
    logic                vld;
    logic                valid;
    logic [CELLS_W-1:0]  cells;
    logic [LAYERS-1:0]   mask;
  } event_sum_t;

  // Number of layers that hold a fired cell.
  function automatic logic [NLAYERS_W-1:0] count_layers(input logic [LAYERS-1:0] mask);
    logic [NLAYERS_W-1:0] n;
    n = '0;
    for (int i = 0; i < LAYERS; i++) begin
      n = n + NLAYERS_W'(mask[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/chc_event_tally.sv =====
module chc_event_tally (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  chc_pkg::cell_item_t   item_i,
  input  chc_pkg::thr_t         thr_i,
  input  logic                  adv_i,
  output chc_pkg::event_sum_t   sum_o
);

  logic [chc_pkg::CELLS_W-1:0] cnt_q, cnt_d, cnt_next;
  logic [chc_pkg::LAYERS-1:0]  mask_q, mask_d, mask_next;
  logic                        sum_vld_q;
  logic                        sum_valid_q;
  logic [chc_pkg::CELLS_W-1:0] sum_cells_q;
  logic [chc_pkg::LAYERS-1:0]  sum_mask_q;
  logic signed [chc_pkg::ENERGY_W-1:0] thr;
  logic                        in_range;
  logic                        fire;
  logic                        ev_valid;

  // Pick the threshold of the segment that the layer belongs to.
  always_comb begin
    priority if (item_i.layer < chc_pkg::LAYER_W'(chc_pkg::FRONT_END)) begin
      thr = thr_i.front;
    end else if (item_i.layer < chc_pkg::LAYER_W'(chc_pkg::MIDDLE_END)) begin
      thr = thr_i.middle;
    end else begin
      thr = thr_i.back;
    end
  end

  // A cell fires when it sits in a real layer and reaches its threshold.
  assign in_range = item_i.layer < chc_pkg::LAYER_W'(chc_pkg::LAYERS);
  assign fire     = item_i.has_cell && in_range && (item_i.energy >= thr);
  assign ev_valid = item_i.primary > 0;

  // Event state including the current cell; the count saturates.
  always_comb begin
    cnt_next  = cnt_q;
    mask_next = mask_q;
    if (fire) begin
      if (cnt_q < chc_pkg::CELLS_W'(chc_pkg::MAX_CELLS)) begin
        cnt_next = cnt_q + chc_pkg::CELLS_W'(1);
      end
      mask_next = mask_q | (chc_pkg::LAYERS'(1) << item_i.layer);
    end
  end

  // The event state clears once the last item of the event is taken.
  always_comb begin
    cnt_d  = cnt_q;
    mask_d = mask_q;
    if (accept_i) begin
      if (item_i.last) begin
        cnt_d  = '0;
        mask_d = '0;
      end else begin
        cnt_d  = cnt_next;
        mask_d = mask_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      mask_q    <= '0;
      sum_vld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      mask_q <= mask_d;
      if (adv_i) begin
        sum_vld_q <= accept_i && item_i.last;
      end
    end
  end

  // Summary of the closed event; an invalid event reports nothing fired.
  always_ff @(posedge clk_i) begin
    if (adv_i && accept_i && item_i.last) begin
      sum_valid_q <= ev_valid;
      sum_cells_q <= ev_valid ? cnt_next : '0;
      sum_mask_q  <= ev_valid ? mask_next : '0;
    end
  end

  assign sum_o.vld   = sum_vld_q;
  assign sum_o.valid = sum_valid_q;
  assign sum_o.cells = sum_cells_q;
  assign sum_o.mask  = sum_mask_q;

endmodule

// ===== rtl/calorimeter_hit_counter_core.sv =====
// Calorimeter hit counter. Cells stream in one per clock, each compared
// against the threshold of its layer segment (front: layers 0-2, middle: 3-5,
// back: 6-9); the item marked tlast closes the event. Every event produces
// one result, carrying the fired cell and layer counts and the saturating
// running statistics over valid events (positive primary energy). The core
// takes one item per cycle through a three-register pipeline: event tally,
// squaring, and accumulation with the result register; only a stalled
// result consumer that lets the pipeline fill holds the input. The user must
// write thresholds through the configuration port only while no event is in
// flight; the block itself does not enforce this.
module calorimeter_hit_counter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes.
  input  logic                               cfg_we_i,
  input  logic [chc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [chc_pkg::ENERGY_W-1:0]       cfg_data_i,
  // Cell stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: cell_edep[23:0], layer[27:24], primary_energy[59:28], zero pad.
  input  logic [chc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: has_cell.
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,
  // Event results.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: fired_cells, fired_layers, detected, valid_events, detected_events,
  // cell_count_sum, cell_count_square_sum, layer_hits_sum,
  // layer_count_square_sum, zero pad.
  output logic [chc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser: event_valid.
  output logic                               m_axis_tuser
);

  chc_pkg::thr_t       thr_q;
  chc_pkg::cell_item_t item;
  chc_pkg::event_sum_t s1;
  logic                accept;
  logic                s1_ready, s2_ready, out_ready;

  logic                             s2_vld_q;
  logic                             s2_valid_q;
  logic [chc_pkg::CELLS_W-1:0]      s2_cells_q;
  logic [chc_pkg::NLAYERS_W-1:0]    s2_layers_q;
  logic [chc_pkg::CELL_SQ_W-1:0]    s2_cell_sq_q;
  logic [chc_pkg::LAYER_SQ_W-1:0]   s2_layer_sq_q;

  logic                             out_vld_q;
  logic                             ev_valid_q;
  logic [chc_pkg::CELLS_W-1:0]      cells_q;
  logic [chc_pkg::NLAYERS_W-1:0]    layers_q;
  logic                             det_q;

  logic [chc_pkg::VALID_TOT_W-1:0]   valid_total_q;
  logic [chc_pkg::DET_TOT_W-1:0]     det_total_q;
  logic [chc_pkg::CELL_SUM_W-1:0]    cell_sum_q;
  logic [chc_pkg::CELL_SQSUM_W-1:0]  cell_sqsum_q;
  logic [chc_pkg::LAYER_SUM_W-1:0]   layer_sum_q;
  logic [chc_pkg::LAYER_SQSUM_W-1:0] layer_sqsum_q;

  logic [chc_pkg::VALID_TOT_W:0]     valid_total_s;
  logic [chc_pkg::DET_TOT_W:0]       det_total_s;
  logic [chc_pkg::CELL_SUM_W:0]      cell_sum_s;
  logic [chc_pkg::CELL_SQSUM_W:0]    cell_sqsum_s;
  logic [chc_pkg::LAYER_SUM_W:0]     layer_sum_s;
  logic [chc_pkg::LAYER_SQSUM_W:0]   layer_sqsum_s;
  logic                              s2_det;
  logic                              load;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (chc_pkg::cfg_reg_e'(cfg_index_i))
        chc_pkg::REG_FRONT:  thr_q.front  <= cfg_data_i;
        chc_pkg::REG_MIDDLE: thr_q.middle <= cfg_data_i;
        chc_pkg::REG_BACK:   thr_q.back   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input transfer.
  assign item.energy   = s_axis_tdata[23:0];
  assign item.layer    = s_axis_tdata[27:24];
  assign item.primary  = s_axis_tdata[59:28];
  assign item.has_cell = s_axis_tuser;
  assign item.last     = s_axis_tlast;

  // Pipeline flow control: a stage moves when the next one is empty or moving.
  assign out_ready     = !out_vld_q || m_axis_tready;
  assign s2_ready      = !s2_vld_q || out_ready;
  assign s1_ready      = !s1.vld || s2_ready;
  assign s_axis_tready = s1_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  chc_event_tally u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .thr_i    (thr_q),
    .adv_i    (s1_ready),
    .sum_o    (s1)
  );

  // Second stage: layer count and the two squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_q <= s1.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1.vld) begin
      s2_valid_q    <= s1.valid;
      s2_cells_q    <= s1.cells;
      s2_layers_q   <= chc_pkg::count_layers(s1.mask);
      s2_cell_sq_q  <= chc_pkg::CELL_SQ_W'(s1.cells) * chc_pkg::CELL_SQ_W'(s1.cells);
      s2_layer_sq_q <= chc_pkg::LAYER_SQ_W'(chc_pkg::count_layers(s1.mask))
                     * chc_pkg::LAYER_SQ_W'(chc_pkg::count_layers(s1.mask));
    end
  end

  // Saturating updates of the running totals.
  assign s2_det        = s2_valid_q && (s2_layers_q != '0);
  assign load          = s2_vld_q && out_ready;
  assign valid_total_s = {1'b0, valid_total_q} + (chc_pkg::VALID_TOT_W + 1)'(1);
  assign det_total_s   = {1'b0, det_total_q} + (chc_pkg::DET_TOT_W + 1)'(1);
  assign cell_sum_s    = {1'b0, cell_sum_q} + (chc_pkg::CELL_SUM_W + 1)'(s2_cells_q);
  assign cell_sqsum_s  = {1'b0, cell_sqsum_q} + (chc_pkg::CELL_SQSUM_W + 1)'(s2_cell_sq_q);
  assign layer_sum_s   = {1'b0, layer_sum_q} + (chc_pkg::LAYER_SUM_W + 1)'(s2_layers_q);
  assign layer_sqsum_s = {1'b0, layer_sqsum_q}
                       + (chc_pkg::LAYER_SQSUM_W + 1)'(s2_layer_sq_q);

  // Accumulators change only when a result loads, so they feed the output directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q     <= 1'b0;
      valid_total_q <= '0;
      det_total_q   <= '0;
      cell_sum_q    <= '0;
      cell_sqsum_q  <= '0;
      layer_sum_q   <= '0;
      layer_sqsum_q <= '0;
    end else begin
      if (out_ready) begin
        out_vld_q <= s2_vld_q;
      end
      if (load && s2_valid_q) begin
        valid_total_q <= valid_total_s[chc_pkg::VALID_TOT_W] ? '1
                       : valid_total_s[chc_pkg::VALID_TOT_W-1:0];
        if (s2_det) begin
          det_total_q <= det_total_s[chc_pkg::DET_TOT_W] ? '1
                       : det_total_s[chc_pkg::DET_TOT_W-1:0];
        end
        cell_sum_q    <= cell_sum_s[chc_pkg::CELL_SUM_W] ? '1
                       : cell_sum_s[chc_pkg::CELL_SUM_W-1:0];
        cell_sqsum_q  <= cell_sqsum_s[chc_pkg::CELL_SQSUM_W] ? '1
                       : cell_sqsum_s[chc_pkg::CELL_SQSUM_W-1:0];
        layer_sum_q   <= layer_sum_s[chc_pkg::LAYER_SUM_W] ? '1
                       : layer_sum_s[chc_pkg::LAYER_SUM_W-1:0];
        layer_sqsum_q <= layer_sqsum_s[chc_pkg::LAYER_SQSUM_W] ? '1
                       : layer_sqsum_s[chc_pkg::LAYER_SQSUM_W-1:0];
      end
    end
  end

  // Per-event part of the result register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_valid_q <= s2_valid_q;
      cells_q    <= s2_cells_q;
      layers_q   <= s2_layers_q;
      det_q      <= s2_det;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = ev_valid_q;
  assign m_axis_tdata  = {{chc_pkg::OUT_PAD_W{1'b0}}, layer_sqsum_q, layer_sum_q,
                          cell_sqsum_q, cell_sum_q, det_total_q, valid_total_q,
                          det_q, layers_q, cells_q};

  // A stalled result keeps the valid event total and the cell square sum frozen.
  a_totals_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> $stable(valid_total_q) && $stable(cell_sqsum_q))
    else $error("running totals changed under a stalled result");

  // Only a valid event can be detected.
  a_det_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!det_q || ev_valid_q))
    else $error("detected set on an invalid event");

  // An invalid event reports no fired cells or layers.
  a_invalid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !ev_valid_q |-> (cells_q == '0) && (layers_q == '0))
    else $error("invalid event reports fired cells");

  // Detected events never outnumber valid events.
  a_det_le_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_total_q <= valid_total_q)
    else $error("detected count exceeds valid count");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Block constants taken from the package.
  localparam int unsigned LAYERS        = chc_pkg::LAYERS;
  localparam int unsigned MAX_CELLS     = chc_pkg::MAX_CELLS;
  localparam int unsigned FRONT_END     = chc_pkg::FRONT_END;
  localparam int unsigned MIDDLE_END    = chc_pkg::MIDDLE_END;
  localparam int unsigned ENERGY_W      = chc_pkg::ENERGY_W;
  localparam int unsigned LAYER_W       = chc_pkg::LAYER_W;
  localparam int unsigned PRIMARY_W     = chc_pkg::PRIMARY_W;
  localparam int unsigned CELLS_W       = chc_pkg::CELLS_W;
  localparam int unsigned NLAYERS_W     = chc_pkg::NLAYERS_W;
  localparam int unsigned VALID_TOT_W   = chc_pkg::VALID_TOT_W;
  localparam int unsigned DET_TOT_W     = chc_pkg::DET_TOT_W;
  localparam int unsigned CELL_SUM_W    = chc_pkg::CELL_SUM_W;
  localparam int unsigned CELL_SQSUM_W  = chc_pkg::CELL_SQSUM_W;
  localparam int unsigned LAYER_SUM_W   = chc_pkg::LAYER_SUM_W;
  localparam int unsigned LAYER_SQSUM_W = chc_pkg::LAYER_SQSUM_W;
  localparam int unsigned IN_DATA_W     = chc_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W    = chc_pkg::OUT_DATA_W;
  localparam int unsigned OUT_PAD_W     = chc_pkg::OUT_PAD_W;
  localparam int unsigned CFG_IDX_W     = chc_pkg::CFG_IDX_W;

  typedef chc_pkg::cell_item_t cell_item_t;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LEFTOVER_WAIT = 4000;
  localparam longint TIMEOUT_NS = 64'd6_000_000;
  localparam longint ENERGY_MIN = -64'sd8388608;
  localparam longint ENERGY_MAX = 64'sd8388607;

  // Bit offsets of the result fields in m_axis_tdata.
  localparam int unsigned OFS_LAYERS = CELLS_W;
  localparam int unsigned OFS_DET    = OFS_LAYERS + NLAYERS_W;
  localparam int unsigned OFS_VTOT   = OFS_DET + 1;
  localparam int unsigned OFS_DTOT   = OFS_VTOT + VALID_TOT_W;
  localparam int unsigned OFS_CSUM   = OFS_DTOT + DET_TOT_W;
  localparam int unsigned OFS_CSQ    = OFS_CSUM + CELL_SUM_W;
  localparam int unsigned OFS_LSUM   = OFS_CSQ + CELL_SQSUM_W;
  localparam int unsigned OFS_LSQ    = OFS_LSUM + LAYER_SUM_W;

  // Index just past the threshold registers; no register sits behind it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(chc_pkg::REG_BACK)
                                             + CFG_IDX_W'(1);

  // Contents of one event result.
  typedef struct {
    bit                     valid;
    bit [CELLS_W-1:0]       cells;
    bit [NLAYERS_W-1:0]     layers;
    bit                     det;
    bit [VALID_TOT_W-1:0]   n_valid;
    bit [DET_TOT_W-1:0]     n_detected;
    bit [CELL_SUM_W-1:0]    cell_sum;
    bit [CELL_SQSUM_W-1:0]  cell_sqsum;
    bit [LAYER_SUM_W-1:0]   layer_sum;
    bit [LAYER_SQSUM_W-1:0] layer_sqsum;
  } event_stats_t;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [ENERGY_W-1:0]       cfg_data_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // tdata: cell_edep, layer, primary_energy, zero pad.
  logic [IN_DATA_W-1:0]      s_axis_tdata = '0;
  // tuser: has_cell.
  logic                      s_axis_tuser = 1'b0;
  logic                      s_axis_tlast = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // tdata: fired_cells, fired_layers, detected, valid_events, detected_events,
  // cell_count_sum, cell_count_square_sum, layer_hits_sum,
  // layer_count_square_sum, zero pad.
  logic [OUT_DATA_W-1:0]     m_axis_tdata;
  // tuser: event_valid.
  logic                      m_axis_tuser;

  // Predicted block state.
  logic signed [ENERGY_W-1:0] thr_front = '0;
  logic signed [ENERGY_W-1:0] thr_middle = '0;
  logic signed [ENERGY_W-1:0] thr_back = '0;
  int unsigned                ev_cells = 0;
  bit [LAYERS-1:0]            ev_mask = '0;
  bit [63:0]                  tot_valid = '0;
  bit [63:0]                  tot_detected = '0;
  bit [63:0]                  tot_cells = '0;
  bit [63:0]                  tot_cells_sq = '0;
  bit [63:0]                  tot_layers = '0;
  bit [63:0]                  tot_layers_sq = '0;

  event_stats_t pending_stats[$];
  int unsigned  mismatch_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  calorimeter_hit_counter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Hard limit on the run time.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: done, errors");
    $finish;
  end

  // Result consumer stalls at random.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Saturating add at a given accumulator width.
  function automatic bit [63:0] sat_add(input bit [63:0] acc, input bit [63:0] add,
                                        input int unsigned w);
    bit [64:0] lim;
    bit [64:0] sum;
    lim = (65'd1 << w) - 65'd1;
    sum = {1'b0, acc} + {1'b0, add};
    return (sum > lim) ? lim[63:0] : sum[63:0];
  endfunction

  function automatic logic signed [ENERGY_W-1:0] segment_threshold(
      input logic [LAYER_W-1:0] layer);
    if (layer < FRONT_END) begin
      return thr_front;
    end else if (layer < MIDDLE_END) begin
      return thr_middle;
    end
    return thr_back;
  endfunction

  // Fold one accepted cell into the event and close the event on its last item.
  function automatic void tally_cell(input cell_item_t c);
    event_stats_t s;
    bit [63:0]    cells;
    bit [63:0]    layers;
    if (c.has_cell && c.layer < LAYERS) begin
      if ($signed(c.energy) >= segment_threshold(c.layer)) begin
        if (ev_cells < MAX_CELLS) begin
          ev_cells++;
        end
        ev_mask[c.layer] = 1'b1;
      end
    end
    if (!c.last) begin
      return;
    end
    s.valid = ($signed(c.primary) > 0);
    cells   = s.valid ? 64'(ev_cells) : 64'd0;
    layers  = s.valid ? 64'($countones(ev_mask)) : 64'd0;
    s.det   = s.valid && (layers != 0);
    if (s.valid) begin
      tot_valid = sat_add(tot_valid, 64'd1, VALID_TOT_W);
      if (s.det) begin
        tot_detected = sat_add(tot_detected, 64'd1, DET_TOT_W);
      end
      tot_cells     = sat_add(tot_cells, cells, CELL_SUM_W);
      tot_cells_sq  = sat_add(tot_cells_sq, cells * cells, CELL_SQSUM_W);
      tot_layers    = sat_add(tot_layers, layers, LAYER_SUM_W);
      tot_layers_sq = sat_add(tot_layers_sq, layers * layers, LAYER_SQSUM_W);
    end
    s.cells       = cells[CELLS_W-1:0];
    s.layers      = layers[NLAYERS_W-1:0];
    s.n_valid     = tot_valid[VALID_TOT_W-1:0];
    s.n_detected  = tot_detected[DET_TOT_W-1:0];
    s.cell_sum    = tot_cells[CELL_SUM_W-1:0];
    s.cell_sqsum  = tot_cells_sq;
    s.layer_sum   = tot_layers[LAYER_SUM_W-1:0];
    s.layer_sqsum = tot_layers_sq[LAYER_SQSUM_W-1:0];
    pending_stats.push_back(s);
    ev_cells = 0;
    ev_mask  = '0;
  endfunction

  // Compare each result transfer with the oldest pending event.
  always @(posedge clk_i) begin
    event_stats_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result with no pending event", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_stats.pop_front();
        check_field("event_valid", m_axis_tuser, want.valid);
        check_field("fired_cells", m_axis_tdata[0 +: CELLS_W], want.cells);
        check_field("fired_layers", m_axis_tdata[OFS_LAYERS +: NLAYERS_W], want.layers);
        check_field("detected", m_axis_tdata[OFS_DET], want.det);
        check_field("valid_events", m_axis_tdata[OFS_VTOT +: VALID_TOT_W], want.n_valid);
        check_field("detected_events", m_axis_tdata[OFS_DTOT +: DET_TOT_W],
                    want.n_detected);
        check_field("cell_count_sum", m_axis_tdata[OFS_CSUM +: CELL_SUM_W],
                    want.cell_sum);
        check_field("cell_count_square_sum", m_axis_tdata[OFS_CSQ +: CELL_SQSUM_W],
                    want.cell_sqsum);
        check_field("layer_hits_sum", m_axis_tdata[OFS_LSUM +: LAYER_SUM_W],
                    want.layer_sum);
        check_field("layer_count_square_sum", m_axis_tdata[OFS_LSQ +: LAYER_SQSUM_W],
                    want.layer_sqsum);
        check_field("tdata pad", m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W], '0);
      end
    end
  end

  function automatic cell_item_t mk_cell(input longint energy, input int unsigned layer,
                                         input bit has_cell, input longint primary,
                                         input bit last);
    cell_item_t c;
    c.energy   = energy[ENERGY_W-1:0];
    c.layer    = layer[LAYER_W-1:0];
    c.has_cell = has_cell;
    c.primary  = primary[PRIMARY_W-1:0];
    c.last     = last;
    return c;
  endfunction

  // Send one cell; called and returns at a falling edge.
  task automatic send_cell(input cell_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - ENERGY_W - LAYER_W - PRIMARY_W){1'b0}},
                      c.primary, c.layer, c.energy};
    s_axis_tuser  <= c.has_cell;
    s_axis_tlast  <= c.last;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    tally_cell(c);
    @(negedge clk_i);
  endtask

  // Stop the cell stream and let every event result drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_stats.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                 input logic signed [ENERGY_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    case (idx)
      chc_pkg::REG_FRONT: begin
        thr_front = v;
      end
      chc_pkg::REG_MIDDLE: begin
        thr_middle = v;
      end
      chc_pkg::REG_BACK: begin
        thr_back = v;
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all_thresholds(input logic signed [ENERGY_W-1:0] front,
                                      input logic signed [ENERGY_W-1:0] middle,
                                      input logic signed [ENERGY_W-1:0] back);
    settle();
    write_threshold(chc_pkg::REG_FRONT, front);
    write_threshold(chc_pkg::REG_MIDDLE, middle);
    write_threshold(chc_pkg::REG_BACK, back);
  endtask

  function automatic logic signed [ENERGY_W-1:0] random_threshold();
    case ($urandom_range(7))
      0: return ENERGY_MIN[ENERGY_W-1:0];
      1: return ENERGY_MAX[ENERGY_W-1:0];
      2: return ENERGY_W'($urandom());
      default: return ENERGY_W'(longint'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  // Energies mix values near the threshold of the cell's segment with random, extreme and small ones.
  function automatic logic [ENERGY_W-1:0] pick_energy(input logic [LAYER_W-1:0] layer);
    longint v;
    v = segment_threshold(layer);
    case ($urandom_range(5))
      0: return ENERGY_W'($urandom());
      1: v = v + longint'($urandom_range(4)) - 2;
      2: v = $urandom_range(1) ? ENERGY_MAX : ENERGY_MIN;
      default: v = longint'($urandom_range(4000)) - 2000;
    endcase
    if (v > ENERGY_MAX) begin
      v = ENERGY_MAX;
    end else if (v < ENERGY_MIN) begin
      v = ENERGY_MIN;
    end
    return v[ENERGY_W-1:0];
  endfunction

  function automatic logic [PRIMARY_W-1:0] pick_primary();
    case ($urandom_range(7))
      0: return '0;
      1: return {1'b1, 31'($urandom())};
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return 32'($urandom_range(32'h7fff_ffff, 1));
    endcase
  endfunction

  // Thresholds as they come out of reset, with boundary energies.
  task automatic test_reset_thresholds();
    send_cell(mk_cell(0, 0, 1'b1, 1, 1'b1));
    send_cell(mk_cell(-1, 9, 1'b1, 5, 1'b0));
    send_cell(mk_cell(ENERGY_MAX, 5, 1'b1, 32'h7fff_ffff, 1'b1));
  endtask

  // Each segment uses its own threshold; energy equal to it fires.
  task automatic test_segments();
    write_all_thresholds(24'sd100, -24'sd50, 24'sd1000);
    // The spare index has no register behind it.
    write_threshold(REG_SPARE, 24'sd12345);
    send_cell(mk_cell(100, 2, 1'b1, -7, 1'b0));
    send_cell(mk_cell(-51, 3, 1'b1, 0, 1'b0));
    send_cell(mk_cell(-50, 3, 1'b1, 0, 1'b0));
    send_cell(mk_cell(-50, 5, 1'b1, 0, 1'b0));
    send_cell(mk_cell(999, 6, 1'b1, 0, 1'b0));
    send_cell(mk_cell(1000, 9, 1'b1, 0, 1'b0));
    send_cell(mk_cell(99, 2, 1'b1, 0, 1'b0));
    send_cell(mk_cell(ENERGY_MAX, 7, 1'b0, 10, 1'b1));
  endtask

  // Invalid events, ignored layers, empty markers and the state clear.
  task automatic test_special_events();
    send_cell(mk_cell(5000, 1, 1'b1, 0, 1'b1));
    send_cell(mk_cell(5000, 1, 1'b1, -1, 1'b1));
    send_cell(mk_cell(5000, 4, 1'b1, 0, 1'b0));
    send_cell(mk_cell(0, 0, 1'b0, 32'h8000_0000, 1'b1));
    send_cell(mk_cell(ENERGY_MAX, 10, 1'b1, 3, 1'b0));
    send_cell(mk_cell(ENERGY_MAX, 15, 1'b1, 1, 1'b1));
    send_cell(mk_cell(ENERGY_MAX, 0, 1'b0, 7, 1'b1));
    send_cell(mk_cell(ENERGY_MAX, 8, 1'b1, 2, 1'b1));
  endtask

  // Lowest thresholds fire everything, highest only the top energy.
  task automatic test_threshold_extremes();
    write_all_thresholds(ENERGY_MIN[ENERGY_W-1:0], ENERGY_MIN[ENERGY_W-1:0],
                         ENERGY_MIN[ENERGY_W-1:0]);
    for (int l = 0; l < LAYERS; l++) begin
      send_cell(mk_cell(ENERGY_MIN, l, 1'b1, 11, (l == LAYERS - 1)));
    end
    write_all_thresholds(ENERGY_MAX[ENERGY_W-1:0], ENERGY_MAX[ENERGY_W-1:0],
                         ENERGY_MAX[ENERGY_W-1:0]);
    send_cell(mk_cell(ENERGY_MAX - 1, 1, 1'b1, 0, 1'b0));
    send_cell(mk_cell(ENERGY_MAX, 4, 1'b1, 1, 1'b1));
  endtask

  // An event with more fired cells than the saturation limit of the per-event count.
  task automatic test_cell_overflow();
    write_all_thresholds(ENERGY_MIN[ENERGY_W-1:0], ENERGY_MIN[ENERGY_W-1:0],
                         ENERGY_MIN[ENERGY_W-1:0]);
    for (int k = 0; k < MAX_CELLS + 4; k++) begin
      send_cell(mk_cell(longint'($urandom_range(2000)), k % LAYERS, 1'b1, 1,
                        (k == MAX_CELLS + 3)));
    end
    send_cell(mk_cell(0, 3, 1'b1, 1, 1'b0));
    send_cell(mk_cell(0, 6, 1'b1, 1, 1'b1));
  endtask

  // Random events of random length under fresh thresholds.
  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned items);
    int unsigned sent;
    int unsigned len;
    cell_item_t  c;
    sent = 0;
    write_all_thresholds(random_threshold(), random_threshold(), random_threshold());
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < items) begin
      len = $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        c.layer    = ($urandom_range(9) == 0) ? LAYER_W'($urandom_range(15, 10))
                                              : LAYER_W'($urandom_range(9));
        c.has_cell = ($urandom_range(9) != 0);
        c.energy   = pick_energy(c.layer);
        c.last     = (k == len - 1);
        c.primary  = c.last ? pick_primary() : PRIMARY_W'($urandom());
        send_cell(c);
        sent++;
      end
    end
  endtask

  task automatic finish_run();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_stats.size() != 0 && waited < LEFTOVER_WAIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_stats.size() != 0) begin
      report_mismatch("events with no result", pending_stats.size(), '0);
    end
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  endtask

  initial begin
    send_idle_pct = 23;
    recv_idle_pct = 50;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_thresholds();
    test_segments();
    test_special_events();
    test_threshold_extremes();
    test_cell_overflow();
    test_random_phase(23, 50, 250);
    test_random_phase(50, 23, 250);
    test_random_phase(0, 0, 250);
    finish_run();
  end

endmodule

// ===== calorimeter_hit_counter_core.f =====
rtl/chc_pkg.sv
rtl/chc_event_tally.sv
rtl/calorimeter_hit_counter_core.sv
verif/tb.sv
